FILE: src/ale_pkg.sv
package ale_pkg;

   localparam int CAPACITY_DEF    = 128;
   localparam int ENTRY_WIDTH_DEF = 32;
   localparam int GROUP_SIZE      = 32;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_AT    = 3'd2;
   localparam logic [2:0] OP_REM_FRONT = 3'd3;
   localparam logic [2:0] OP_REM_BACK  = 3'd4;
   localparam logic [2:0] OP_REM_AT    = 3'd5;
   localparam logic [2:0] OP_SEARCH    = 3'd6;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  pos;
      logic [31:0] entry_in;
   } req_type;

   typedef struct packed {
      logic [31:0] entry_out;
      logic        found;
      logic        error;
      logic [7:0]  count_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic ins;
      logic rem;
      logic srch;
   } ctl_type;

   typedef struct packed {
      logic       found_en;
      logic       error;
      logic [7:0] count_out;
   } meta_type;

endpackage

FILE: src/ale_cell.sv
module ale_cell #(
   parameter int ENTRY_WIDTH = ale_pkg::ENTRY_WIDTH_DEF,
   parameter int IDX_WIDTH   = 7,
   parameter int CNT_WIDTH   = 8,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  ale_pkg::ctl_type       ctl,
   input  logic [IDX_WIDTH-1:0]   at,
   input  logic [CNT_WIDTH-1:0]   count,
   input  logic [ENTRY_WIDTH-1:0] value,
   input  logic [ENTRY_WIDTH-1:0] left_data,
   input  logic [ENTRY_WIDTH-1:0] right_data,
   output logic [ENTRY_WIDTH-1:0] data,
   output logic                   hit,
   output logic [ENTRY_WIDTH-1:0] pick
);
   import ale_pkg::*;

   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [ENTRY_WIDTH-1:0] data_in;
   logic                   hit_ff;
   logic [ENTRY_WIDTH-1:0] pick_ff;
   logic                   at_me;
   logic                   past_at;
   logic                   held;

   assign at_me   = (at == IDX_WIDTH'(INDEX));
   assign past_at = (IDX_WIDTH'(INDEX) > at);
   assign held    = (CNT_WIDTH'(INDEX) < count);

   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (at_me) begin
            data_in = value;
         end else if (past_at) begin
            data_in = left_data;
         end
      end else if (ctl.rem) begin
         if (at_me || past_at) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctl.load) begin
         hit_ff  <= ctl.srch && held && (data_ff == value);
         pick_ff <= (ctl.rem && at_me) ? data_ff : '0;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;
   assign pick = pick_ff;

endmodule

FILE: src/ale_reduce.sv
module ale_reduce #(
   parameter int CAPACITY    = ale_pkg::CAPACITY_DEF,
   parameter int ENTRY_WIDTH = ale_pkg::ENTRY_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [CAPACITY-1:0]    hit_vec,
   input  logic [ENTRY_WIDTH-1:0] pick_vec [CAPACITY],
   output logic                   any_hit,
   output logic [ENTRY_WIDTH-1:0] pick_out
);
   import ale_pkg::*;

   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   logic                   grp_hit_in  [NUM_GROUPS];
   logic [ENTRY_WIDTH-1:0] grp_pick_in [NUM_GROUPS];
   logic                   grp_hit_ff  [NUM_GROUPS];
   logic [ENTRY_WIDTH-1:0] grp_pick_ff [NUM_GROUPS];

   // first level: or within each group
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_hit_in[g]  = 1'b0;
         grp_pick_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               grp_hit_in[g]  = grp_hit_in[g] | hit_vec[g * GROUP_SIZE + k];
               grp_pick_in[g] = grp_pick_in[g] | pick_vec[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_hit_ff[g]  <= grp_hit_in[g];
            grp_pick_ff[g] <= grp_pick_in[g];
         end
      end
   end

   // second level: or across groups
   always_comb begin
      any_hit  = 1'b0;
      pick_out = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         any_hit  = any_hit | grp_hit_ff[g];
         pick_out = pick_out | grp_pick_ff[g];
      end
   end

endmodule

FILE: src/array_list_engine_unit.sv
// channel | dir | payload              | handshake
// req     | in  | op, pos, entry_in    | req_valid / req_ready
// rsp     | out | entry_out, found,    | rsp_valid / rsp_ready
//         |     | error, count_out     |
//
// one beat in flight at a time; its result passes the entry cell registers and
// the group registers of the two-level hit/pick or tree that follows the row of
// entry cells before it reaches the output register. a new beat is taken once
// the previous result sits in the output register, so at most one more result
// waits behind a stalled rsp.
// reset clears the count and all handshake state; entry cells are not cleared.
module array_list_engine_unit #(
   parameter int CAPACITY    = ale_pkg::CAPACITY_DEF,
   parameter int ENTRY_WIDTH = ale_pkg::ENTRY_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ale_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ale_pkg::rsp_type rsp_data
);
   import ale_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int XW = (CW > 8) ? CW : 8;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   busy_ff;
   logic                   s1_valid_ff;
   logic                   s2_valid_ff;
   logic                   rsp_valid_ff;
   meta_type               s1_meta_ff;
   meta_type               s2_meta_ff;
   meta_type               meta_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic                   accept;
   logic                   s2_adv;
   logic [XW-1:0]          count_x;
   logic [XW-1:0]          pos_x;
   logic [XW-1:0]          at_x;
   logic                   err;
   ctl_type                ctl;
   logic [ENTRY_WIDTH-1:0] value;

   logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
   logic [ENTRY_WIDTH-1:0] cell_pick [CAPACITY];
   logic [CAPACITY-1:0]    cell_hit;
   logic                   any_hit;
   logic [ENTRY_WIDTH-1:0] pick_out;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      for (int b = 0; b < ENTRY_WIDTH; b++) begin
         value[b] = (b < 32) ? req_data.entry_in[b] : 1'b0;
      end
   end

   // decode and range checks
   always_comb begin
      count_x = XW'(count_ff);
      pos_x   = XW'(req_data.pos);
      at_x    = '0;
      err     = 1'b0;
      ctl     = '0;
      unique case (req_data.op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (req_data.op == OP_INS_FRONT) begin
               at_x = '0;
            end else if (req_data.op == OP_INS_BACK) begin
               at_x = count_x;
            end else begin
               at_x = pos_x;
            end
            err     = (count_x >= XW'(CAPACITY)) || (at_x > count_x);
            ctl.ins = !err;
         end
         OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
            if (req_data.op == OP_REM_FRONT) begin
               at_x = '0;
            end else if (req_data.op == OP_REM_BACK) begin
               at_x = count_x - ((count_x != '0) ? XW'(1) : XW'(0));
            end else begin
               at_x = pos_x;
            end
            err     = (count_x == '0) || (at_x >= count_x);
            ctl.rem = !err;
         end
         OP_SEARCH: begin
            ctl.srch = 1'b1;
         end
         default: begin
         end
      endcase
      ctl.load = accept;
      ctl.ins  = ctl.ins && accept;
      ctl.rem  = ctl.rem && accept;
      ctl.srch = ctl.srch && accept;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.rem) begin
         count_in = count_ff - CW'(1);
      end
      meta_in.found_en = (req_data.op == OP_SEARCH);
      meta_in.error    = err;
      for (int b = 0; b < 8; b++) begin
         meta_in.count_out[b] = (b < CW) ? count_in[b] : 1'b0;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_data;
      logic [ENTRY_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = value;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end
      ale_cell #(
         .ENTRY_WIDTH(ENTRY_WIDTH),
         .IDX_WIDTH  (IW),
         .CNT_WIDTH  (CW),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .at        (at_x[IW-1:0]),
         .count     (count_ff),
         .value     (value),
         .left_data (left_data),
         .right_data(right_data),
         .data      (cell_data[i]),
         .hit       (cell_hit[i]),
         .pick      (cell_pick[i])
      );
   end

   ale_reduce #(
      .CAPACITY   (CAPACITY),
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_reduce (
      .clock   (clock),
      .load    (s1_valid_ff),
      .hit_vec (cell_hit),
      .pick_vec(cell_pick),
      .any_hit (any_hit),
      .pick_out(pick_out)
   );

   always_comb begin
      for (int b = 0; b < 32; b++) begin
         rsp_in.entry_out[b] = (b < ENTRY_WIDTH) ? pick_out[b] : 1'b0;
      end
      rsp_in.found     = any_hit && s2_meta_ff.found_en;
      rsp_in.error     = s2_meta_ff.error;
      rsp_in.count_out = s2_meta_ff.count_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         s1_valid_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (s2_adv) begin
            busy_ff <= 1'b0;
         end
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta_in;
      end
      if (s1_valid_ff) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (s2_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: bench/array_list_engine_unit_tb.sv
`timescale 1ns / 1ps

module array_list_engine_unit_tb;
   import ale_pkg::*;

   localparam int          CAPACITY    = CAPACITY_DEF;
   localparam logic [2:0]  OP_UNUSED   = 3'd7;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          REPORT_MAX  = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic [31:0] list_store [CAPACITY];
   int unsigned list_len;
   rsp_type     rsp_due [$];
   int          mismatch_count;
   int          cycle_count;
   int          stall_left;
   bit          no_idle;

   array_list_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // list behavior: shift on insert/remove, search, full/empty/position checks
   function automatic rsp_type list_apply(req_type item);
      rsp_type     r;
      int unsigned p;
      int unsigned i;
      r = '0;
      case (item.op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (item.op == OP_INS_FRONT) p = 0;
            else if (item.op == OP_INS_BACK) p = list_len;
            else p = item.pos;
            if (list_len >= CAPACITY || p > list_len) begin
               r.error = 1'b1;
            end else begin
               for (i = list_len; i > p; i--) list_store[i] = list_store[i - 1];
               list_store[p] = item.entry_in;
               list_len++;
            end
         end
         OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
            if (item.op == OP_REM_FRONT) p = 0;
            else if (item.op == OP_REM_BACK) p = (list_len > 0) ? list_len - 1 : 0;
            else p = item.pos;
            if (list_len == 0 || p >= list_len) begin
               r.error = 1'b1;
            end else begin
               r.entry_out = list_store[p];
               for (i = p; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
               list_len--;
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < list_len; i++) begin
               if (list_store[i] == item.entry_in) begin
                  r.found = 1'b1;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      r.count_out = list_len[7:0];
      return r;
   endfunction

   function automatic req_type make_req(logic [2:0] op, int pos, logic [31:0] value);
      req_type item;
      item.op       = op;
      item.pos      = pos[7:0];
      item.entry_in = value;
      return item;
   endfunction

   task automatic send_beat(req_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      rsp_due.push_back(list_apply(item));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom_range(0, 15);
      if (r == 4) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   function automatic req_type pick_insert();
      int r;
      r = $urandom_range(0, 2);
      if (r == 0) return make_req(OP_INS_FRONT, $urandom_range(0, 255), pick_value());
      if (r == 1) return make_req(OP_INS_BACK, $urandom_range(0, 255), pick_value());
      if ($urandom_range(0, 4) == 0)
         return make_req(OP_INS_AT, $urandom_range(0, 255), pick_value());
      return make_req(OP_INS_AT, $urandom_range(0, list_len), pick_value());
   endfunction

   function automatic req_type pick_remove();
      int r;
      int top;
      r   = $urandom_range(0, 2);
      top = (list_len > 0) ? list_len - 1 : 0;
      if (r == 0) return make_req(OP_REM_FRONT, $urandom_range(0, 255), $urandom());
      if (r == 1) return make_req(OP_REM_BACK, $urandom_range(0, 255), $urandom());
      if ($urandom_range(0, 4) == 0)
         return make_req(OP_REM_AT, $urandom_range(0, 255), $urandom());
      return make_req(OP_REM_AT, $urandom_range(0, top), $urandom());
   endfunction

   function automatic req_type pick_search();
      if (list_len > 0 && $urandom_range(0, 9) < 6)
         return make_req(OP_SEARCH, $urandom_range(0, 255),
                         list_store[$urandom_range(0, list_len - 1)]);
      return make_req(OP_SEARCH, $urandom_range(0, 255), pick_value());
   endfunction

   task automatic test_empty_list();
      send_beat(make_req(OP_REM_FRONT, 0, 32'h0));
      send_beat(make_req(OP_REM_BACK, 0, 32'h0));
      send_beat(make_req(OP_REM_AT, 0, 32'h0));
      send_beat(make_req(OP_SEARCH, 0, 32'h0));
      send_beat(make_req(OP_UNUSED, 255, 32'hFFFF_FFFF));
      send_beat(make_req(OP_INS_AT, 1, 32'h1234_5678));
      send_beat(make_req(OP_INS_AT, 0, 32'h0));
   endtask

   task automatic test_basic_ops();
      send_beat(make_req(OP_INS_FRONT, 0, 32'hFFFF_FFFF));
      send_beat(make_req(OP_INS_BACK, 255, 32'h8000_0001));
      send_beat(make_req(OP_INS_AT, 1, 32'hA5A5_A5A5));
      send_beat(make_req(OP_INS_AT, 4, 32'h5A5A_5A5A));
      send_beat(make_req(OP_INS_AT, 255, 32'h0));
      send_beat(make_req(OP_SEARCH, 0, 32'hA5A5_A5A5));
      send_beat(make_req(OP_SEARCH, 0, 32'h7FFF_FFFF));
      send_beat(make_req(OP_REM_AT, 255, 32'h0));
      send_beat(make_req(OP_REM_AT, 5, 32'h0));
      send_beat(make_req(OP_REM_AT, 1, 32'h0));
      send_beat(make_req(OP_REM_FRONT, 0, 32'h0));
      send_beat(make_req(OP_REM_BACK, 0, 32'h0));
      send_beat(make_req(OP_UNUSED, 0, 32'h0));
      send_beat(make_req(OP_SEARCH, 0, 32'h0));
   endtask

   task automatic test_fill_overflow();
      while (list_len < CAPACITY) send_beat(pick_insert());
      send_beat(make_req(OP_INS_FRONT, 0, 32'h1));
      send_beat(make_req(OP_INS_BACK, 0, 32'h2));
      send_beat(make_req(OP_INS_AT, CAPACITY, 32'h3));
      send_beat(make_req(OP_SEARCH, 0, list_store[CAPACITY - 1]));
      wait_drained();
      while (list_len > 0) send_beat(pick_remove());
      send_beat(make_req(OP_REM_BACK, 0, 32'h0));
   endtask

   task automatic test_random_mix();
      int phase;
      int n;
      int r;
      int ins_weight;
      for (phase = 0; phase < 8; phase++) begin
         no_idle    = (phase == 3);
         ins_weight = (phase % 2 == 0) ? 60 : 22;
         for (n = 0; n < 105; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) send_beat(make_req(OP_UNUSED, $urandom_range(0, 255), $urandom()));
            else if (r < 18) send_beat(pick_search());
            else if (r < 18 + ins_weight) send_beat(pick_insert());
            else send_beat(pick_remove());
         end
         if (phase == 4) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected rsp beat: %p", rsp_data);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_data.entry_out !== want.entry_out || rsp_data.found !== want.found ||
                rsp_data.error !== want.error || rsp_data.count_out !== want.count_out) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("rsp mismatch: expected entry_out=%h found=%b error=%b count=%0d",
                           want.entry_out, want.found, want.error, want.count_out,
                           " got entry_out=%h found=%b error=%b count=%0d",
                           rsp_data.entry_out, rsp_data.found, rsp_data.error,
                           rsp_data.count_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("array_list_engine_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      list_len       = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      stall_left     = 0;
      no_idle        = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_basic_ops();
      wait_drained();
      test_fill_overflow();
      test_random_mix();

      wait_drained();
      repeat (10) @(negedge clock);
      if (rsp_due.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("array_list_engine_unit_tb: clean");
      end else begin
         $display("array_list_engine_unit_tb: errors");
      end
      $finish;
   end

endmodule
